// ----- rtl/lyap_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lyap_pkg
// Shared types, codes and helpers for the Smith-iteration Lyapunov solver.
// ----------------------------------------------------------------------------
package lyap_pkg;

  localparam int IDX_W  = 3;            // row / column index
  localparam int ADDR_W = 2 * IDX_W;    // {row, col} store address
  localparam int DEPTH  = 1 << ADDR_W;  // store depth
  localparam int DATA_W = 32;           // Q8.24 element
  localparam int PROD_W = 64;           // exact product
  localparam int TERM_W = 40;           // rounded product
  localparam int ACC_W  = 48;           // dot-product accumulator
  localparam int DIFF_W = 40;           // squared-change accumulator
  localparam int ITER_W = 16;
  localparam int FRAC_BITS = 24;

  // input modes
  localparam logic [1:0] MODE_LOAD_A = 2'd0;
  localparam logic [1:0] MODE_LOAD_Q = 2'd1;
  localparam logic [1:0] MODE_SOLVE  = 2'd2;

  // register indexes
  localparam logic [1:0] REG_DIMENSION = 2'd0;
  localparam logic [1:0] REG_ITER_LIM  = 2'd1;
  localparam logic [1:0] REG_TOL_SQ    = 2'd2;

  // command from controller to datapath, one per cycle
  typedef struct packed {
    logic             valid;
    logic             copy;   // P <= Q sweep
    logic             ph1;    // product = P * A
    logic             ph2;    // P = Q + A^T * product
    logic             emit;   // read P for output
    logic             first;  // first term of a dot product
    logic             last;   // last term, or last output element
    logic [IDX_W-1:0] i;
    logic [IDX_W-1:0] j;
    logic [IDX_W-1:0] k;
  } lyap_cmd_t;

  // element load from the input channel
  typedef struct packed {
    logic              we_a;
    logic              we_q;
    logic [ADDR_W-1:0] addr;
    logic [DATA_W-1:0] data;
  } lyap_load_t;

  // status from datapath back to controller
  typedef struct packed {
    logic              big;      // some change of 2^16 or more
    logic [DIFF_W-1:0] diff;     // summed squared change
    logic              out_fire; // output beat taken
  } lyap_stat_t;

  // clamp to a signed range of the given width (16..32)
  function automatic logic signed [DATA_W-1:0] sat_val(input logic signed [ACC_W-1:0] v,
                                                       input int bits);
    logic signed [ACC_W-1:0] hi;
    logic signed [ACC_W-1:0] lo;
    hi = (48'sd1 <<< (bits - 1)) - 48'sd1;
    lo = -hi - 48'sd1;
    if (v > hi) return hi[DATA_W-1:0];
    else if (v < lo) return lo[DATA_W-1:0];
    else return v[DATA_W-1:0];
  endfunction

endpackage

// ----- rtl/lyap_in_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lyap_in_if
// Input channel: element loads and solve requests.
// ----------------------------------------------------------------------------
interface lyap_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [2:0]  row;
  logic [2:0]  col;
  logic [31:0] value;

  modport source (output valid, mode, row, col, value, input ready);
  modport sink   (input valid, mode, row, col, value, output ready);
endinterface

// ----- rtl/lyap_out_if.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lyap_out_if
// Output channel: solution elements with status.
// ----------------------------------------------------------------------------
interface lyap_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  out_row;
  logic [2:0]  out_col;
  logic [31:0] p_value;
  logic        converged;
  logic [15:0] iterations_used;
  logic        last;

  modport source (output valid, out_row, out_col, p_value, converged, iterations_used, last,
                  input ready);
  modport sink   (input valid, out_row, out_col, p_value, converged, iterations_used, last,
                  output ready);
endinterface

// ----- rtl/discrete_lyapunov_smith_solver_unit.sv -----
`timescale 1ns / 1ps
// Element loads: one beat per cycle while idle, no result.
// Solve: a copy sweep of Q into P, then per iteration two matrix-product phases
//   (one multiply-accumulate per cycle in a single lane), then n*n output
//   beats, each held until the sink is ready. Input is held off meanwhile.
// Reset (synchronous, rst high) returns the sequencer to idle and restores
//   the register defaults; the matrix stores keep their contents.
// ----------------------------------------------------------------------------
// discrete_lyapunov_smith_solver_unit
// Solves P = Q + A^T P A by Smith iteration in signed Q8.24 fixed point.
// ----------------------------------------------------------------------------
module discrete_lyapunov_smith_solver_unit import lyap_pkg::*; #(
  parameter int MAX_ORDER  = 8,
  parameter int VALUE_BITS = 32
) (
  input  logic        clk,
  input  logic        rst,
  lyap_in_if.sink     in_ch,
  lyap_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int SAT_BITS = (VALUE_BITS > 32) ? 32 : ((VALUE_BITS < 16) ? 16 : VALUE_BITS);

  logic [3:0]        dimension;
  logic [ITER_W-1:0] iteration_limit;
  logic [DATA_W-1:0] tolerance_squared;
  logic              cfg_we;
  logic [IDX_W-1:0]  nm1;
  logic              idle, in_fire, in_range, start;
  logic              conv;
  logic [ITER_W-1:0] iters;
  lyap_cmd_t         cmd;
  lyap_load_t        load;
  lyap_stat_t        stat;

  // configuration registers
  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      dimension         <= 4'd8;
      iteration_limit   <= 16'd5000;
      tolerance_squared <= 32'd1;
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_DIMENSION: dimension         <= pwdata[3:0];
        REG_ITER_LIM:  iteration_limit   <= pwdata[15:0];
        REG_TOL_SQ:    tolerance_squared <= pwdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_DIMENSION: prdata = {28'd0, dimension};
      REG_ITER_LIM:  prdata = {16'd0, iteration_limit};
      REG_TOL_SQ:    prdata = tolerance_squared;
      default:       prdata = '0;
    endcase
  end

  // order clamped to 1..MAX_ORDER, kept as n-1
  always_comb begin
    if (dimension == '0) begin
      nm1 = '0;
    end else if (dimension > 4'(MAX_ORDER)) begin
      nm1 = IDX_W'(MAX_ORDER - 1);
    end else begin
      nm1 = IDX_W'(dimension - 4'd1);
    end
  end

  // input beats
  assign in_ch.ready = idle;
  assign in_fire     = in_ch.valid && idle;
  assign in_range    = ({1'b0, in_ch.row} < 4'(MAX_ORDER)) &&
                       ({1'b0, in_ch.col} < 4'(MAX_ORDER));
  assign start       = in_fire && (in_ch.mode == MODE_SOLVE);

  always_comb begin
    load.we_a = in_fire && in_range && (in_ch.mode == MODE_LOAD_A);
    load.we_q = in_fire && in_range && (in_ch.mode == MODE_LOAD_Q);
    load.addr = {in_ch.row, in_ch.col};
    load.data = sat_val(ACC_W'($signed(in_ch.value)), SAT_BITS);
  end

  lyap_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .nm1   (nm1),
    .limit (iteration_limit),
    .tol   (tolerance_squared),
    .stat  (stat),
    .cmd   (cmd),
    .idle  (idle),
    .conv  (conv),
    .iters (iters)
  );

  lyap_datapath #(.SAT_BITS(SAT_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .load      (load),
    .conv      (conv),
    .iters     (iters),
    .out_ready (out_ch.ready),
    .out_valid (out_ch.valid),
    .out_row   (out_ch.out_row),
    .out_col   (out_ch.out_col),
    .out_p     (out_ch.p_value),
    .out_conv  (out_ch.converged),
    .out_iters (out_ch.iterations_used),
    .out_last  (out_ch.last),
    .stat      (stat)
  );

endmodule

// ----- rtl/lyap_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lyap_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lyap_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/lyap_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lyap_datapath
// Matrix stores, one multiply-accumulate lane, update and change tracking,
// and the output register.
// ----------------------------------------------------------------------------
module lyap_datapath import lyap_pkg::*; #(
  parameter int SAT_BITS = 32
) (
  input  logic                clk,
  input  logic                rst,
  input  lyap_cmd_t           cmd,
  input  lyap_load_t          load,
  input  logic                conv,
  input  logic [ITER_W-1:0]   iters,
  input  logic                out_ready,
  output logic                out_valid,
  output logic [IDX_W-1:0]    out_row,
  output logic [IDX_W-1:0]    out_col,
  output logic [DATA_W-1:0]   out_p,
  output logic                out_conv,
  output logic [ITER_W-1:0]   out_iters,
  output logic                out_last,
  output lyap_stat_t          stat
);

  // command tags, one per stage
  lyap_cmd_t t1, t2, t3, t4, t5;

  logic [ADDR_W-1:0] a_raddr, p_raddr, m_raddr, q_raddr;
  logic [DATA_W-1:0] a_rd, q_rd, p_rd, m_rd;

  logic              p_we, m_we;
  logic [ADDR_W-1:0] p_waddr, m_waddr;
  logic [DATA_W-1:0] p_wdata, m_wdata;

  logic signed [DATA_W-1:0] q2, q3, p2, p3;
  logic signed [PROD_W-1:0] prod;
  logic signed [PROD_W-1:0] rnd;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W-1:0]  acc;
  logic signed [DATA_W-1:0] dot_sat;
  logic signed [ACC_W-1:0]  upd_sum;
  logic signed [DATA_W-1:0] np;
  logic signed [DATA_W-1:0] np4, pold4;
  logic signed [DATA_W:0]   delta;
  logic [DATA_W:0]          absd;
  logic [31:0]              sq;
  logic [DIFF_W-1:0]        diff;
  logic                     big;
  logic                     fire;

  // read addresses by phase
  always_comb begin
    a_raddr = cmd.ph2 ? {cmd.k, cmd.i} : {cmd.k, cmd.j};
    p_raddr = cmd.ph1 ? {cmd.i, cmd.k} : {cmd.i, cmd.j};
    m_raddr = {cmd.k, cmd.j};
    q_raddr = {cmd.i, cmd.j};
  end

  lyap_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_a_ram (
    .clk(clk), .we(load.we_a), .waddr(load.addr), .wdata(load.data),
    .raddr(a_raddr), .rdata(a_rd)
  );

  lyap_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_q_ram (
    .clk(clk), .we(load.we_q), .waddr(load.addr), .wdata(load.data),
    .raddr(q_raddr), .rdata(q_rd)
  );

  lyap_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_p_ram (
    .clk(clk), .we(p_we), .waddr(p_waddr), .wdata(p_wdata),
    .raddr(p_raddr), .rdata(p_rd)
  );

  lyap_ram #(.WIDTH(DATA_W), .DEPTH(DEPTH)) u_m_ram (
    .clk(clk), .we(m_we), .waddr(m_waddr), .wdata(m_wdata),
    .raddr(m_raddr), .rdata(m_rd)
  );

  // tag pipeline
  always_ff @(posedge clk) begin
    if (rst) begin
      t1 <= '0;
      t2 <= '0;
      t3 <= '0;
      t4 <= '0;
      t5 <= '0;
    end else begin
      t1 <= cmd;
      t2 <= t1;
      t3 <= t2;
      t4 <= t3;
      t5 <= t4;
    end
  end

  // stage 2: exact product; Q and old P ride along
  always_ff @(posedge clk) begin
    if (t1.ph2) begin
      prod <= $signed(a_rd) * $signed(m_rd);
    end else begin
      prod <= $signed(p_rd) * $signed(a_rd);
    end
    q2 <= q_rd;
    p2 <= p_rd;
    q3 <= q2;
    p3 <= p2;
  end

  // stage 3: round to nearest (ties up) and accumulate
  always_comb begin
    rnd  = prod + (64'sd1 <<< (FRAC_BITS - 1));
    term = rnd[PROD_W-1:FRAC_BITS];
  end

  always_ff @(posedge clk) begin
    if (t2.valid && (t2.ph1 || t2.ph2)) begin
      if (t2.first) begin
        acc <= ACC_W'(term);
      end else begin
        acc <= acc + ACC_W'(term);
      end
    end
  end

  // stage 4: saturate dot product, form new P element
  always_comb begin
    dot_sat = sat_val(acc, SAT_BITS);
    upd_sum = ACC_W'(q3) + ACC_W'(dot_sat);
    np      = sat_val(upd_sum, SAT_BITS);

    m_we    = t3.valid && t3.ph1 && t3.last;
    m_waddr = {t3.i, t3.j};
    m_wdata = dot_sat;

    // copy sweep writes from stage 2, update from stage 4
    if (t1.valid && t1.copy) begin
      p_we    = 1'b1;
      p_waddr = {t1.i, t1.j};
      p_wdata = q_rd;
    end else begin
      p_we    = t3.valid && t3.ph2 && t3.last;
      p_waddr = {t3.i, t3.j};
      p_wdata = np;
    end
  end

  always_ff @(posedge clk) begin
    np4   <= np;
    pold4 <= p3;
  end

  // stage 5: magnitude of change
  always_comb begin
    delta = {np4[DATA_W-1], np4} - {pold4[DATA_W-1], pold4};
  end

  always_ff @(posedge clk) begin
    absd <= delta[DATA_W] ? (DATA_W+1)'(-delta) : delta;
  end

  // square of a small change, full 32-bit product
  always_comb begin
    sq = absd[15:0] * absd[15:0];
  end

  // stage 6: squared-change sum, cleared at the start of each iteration
  always_ff @(posedge clk) begin
    if (rst || (cmd.valid && cmd.ph1)) begin
      diff <= '0;
      big  <= 1'b0;
    end else if (t5.valid && t5.ph2 && t5.last) begin
      if (absd[DATA_W:16] != '0) begin
        big <= 1'b1;
      end else begin
        diff <= diff + DIFF_W'(sq);
      end
    end
  end

  // output register
  assign fire = out_valid && out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (t1.valid && t1.emit) begin
      out_valid <= 1'b1;
    end else if (fire) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (t1.valid && t1.emit) begin
      out_row   <= t1.i;
      out_col   <= t1.j;
      out_p     <= p_rd;
      out_conv  <= conv;
      out_iters <= iters;
      out_last  <= t1.last;
    end
  end

  always_comb begin
    stat.big      = big;
    stat.diff     = diff;
    stat.out_fire = fire;
  end

endmodule

// ----- rtl/lyap_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lyap_ctrl
// Sequencer: copy sweep, two matrix-product phases per iteration,
// convergence check and output sweep.
// ----------------------------------------------------------------------------
module lyap_ctrl import lyap_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [IDX_W-1:0]  nm1,
  input  logic [ITER_W-1:0] limit,
  input  logic [DATA_W-1:0] tol,
  input  lyap_stat_t        stat,
  output lyap_cmd_t         cmd,
  output logic              idle,
  output logic              conv,
  output logic [ITER_W-1:0] iters
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_COPY  = 4'd1;
  localparam logic [3:0] S_DRAIN = 4'd2;
  localparam logic [3:0] S_MUL1  = 4'd3;
  localparam logic [3:0] S_MUL2  = 4'd4;
  localparam logic [3:0] S_CHECK = 4'd5;
  localparam logic [3:0] S_ERD   = 4'd6;
  localparam logic [3:0] S_ELD   = 4'd7;
  localparam logic [3:0] S_EWT   = 4'd8;

  // pipeline depth until stores and change sum are settled
  localparam logic [2:0] DRAIN_CYC = 3'd6;

  logic [3:0]        state, state_next, ret, ret_next;
  logic [IDX_W-1:0]  i, j, k, i_next, j_next, k_next;
  logic [2:0]        dcnt, dcnt_next;
  logic              conv_next;
  logic [ITER_W-1:0] iters_next;
  logic              at_k, at_j, at_i;

  assign at_k = (k == nm1);
  assign at_j = (j == nm1);
  assign at_i = (i == nm1);

  // command decode
  always_comb begin
    cmd.valid = (state == S_COPY) || (state == S_MUL1) || (state == S_MUL2) ||
                (state == S_ERD);
    cmd.copy  = (state == S_COPY);
    cmd.ph1   = (state == S_MUL1);
    cmd.ph2   = (state == S_MUL2);
    cmd.emit  = (state == S_ERD);
    cmd.first = (k == '0);
    cmd.last  = (state == S_ERD) ? (at_i && at_j) : at_k;
    cmd.i     = i;
    cmd.j     = j;
    cmd.k     = k;
  end

  assign idle = (state == S_IDLE);

  // next state
  always_comb begin
    state_next = state;
    ret_next   = ret;
    i_next     = i;
    j_next     = j;
    k_next     = k;
    dcnt_next  = dcnt;
    conv_next  = conv;
    iters_next = iters;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          state_next = S_COPY;
          i_next     = '0;
          j_next     = '0;
          k_next     = '0;
          conv_next  = 1'b0;
          iters_next = '0;
        end
      end
      S_COPY: begin
        j_next = at_j ? '0 : j + 1'b1;
        if (at_j) begin
          i_next = at_i ? '0 : i + 1'b1;
        end
        if (at_i && at_j) begin
          state_next = S_DRAIN;
          dcnt_next  = DRAIN_CYC;
          ret_next   = (limit == '0) ? S_ERD : S_MUL1;
        end
      end
      S_DRAIN: begin
        dcnt_next = dcnt - 1'b1;
        if (dcnt == '0) begin
          state_next = ret;
        end
      end
      S_MUL1, S_MUL2: begin
        k_next = at_k ? '0 : k + 1'b1;
        if (at_k) begin
          j_next = at_j ? '0 : j + 1'b1;
          if (at_j) begin
            i_next = at_i ? '0 : i + 1'b1;
          end
        end
        if (at_i && at_j && at_k) begin
          state_next = S_DRAIN;
          dcnt_next  = DRAIN_CYC;
          ret_next   = (state == S_MUL1) ? S_MUL2 : S_CHECK;
        end
      end
      S_CHECK: begin
        iters_next = iters + 1'b1;
        if (!stat.big && (stat.diff < DIFF_W'(tol))) begin
          conv_next  = 1'b1;
          state_next = S_ERD;
        end else if (iters_next == limit) begin
          state_next = S_ERD;
        end else begin
          state_next = S_MUL1;
        end
      end
      S_ERD: begin
        state_next = S_ELD;
      end
      S_ELD: begin
        state_next = S_EWT;
      end
      S_EWT: begin
        if (stat.out_fire) begin
          if (at_i && at_j) begin
            state_next = S_IDLE;
          end else begin
            state_next = S_ERD;
          end
          j_next = at_j ? '0 : j + 1'b1;
          if (at_j) begin
            i_next = at_i ? '0 : i + 1'b1;
          end
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      ret   <= S_IDLE;
      i     <= '0;
      j     <= '0;
      k     <= '0;
      dcnt  <= '0;
      conv  <= 1'b0;
      iters <= '0;
    end else begin
      state <= state_next;
      ret   <= ret_next;
      i     <= i_next;
      j     <= j_next;
      k     <= k_next;
      dcnt  <= dcnt_next;
      conv  <= conv_next;
      iters <= iters_next;
    end
  end

endmodule

// ----- rtl/lyap_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lyap_checker
// Port-level checks of the solver's input/output sequencing.
// ----------------------------------------------------------------------------
module lyap_checker import lyap_pkg::*; (
  input logic       clk,
  input logic       rst,
  input logic       in_valid,
  input logic       in_ready,
  input logic [1:0] in_mode,
  input logic       out_valid,
  input logic       out_ready,
  input logic       out_last
);

  // a pending output beat holds
  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid)
    else $error("output beat dropped while stalled");

  // input is closed while results are pending
  assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input open while output pending");

  // a solve beat closes the input
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready && (in_mode == MODE_SOLVE) |=> !in_ready)
    else $error("input still open after solve");

  // the final output beat reopens the input
  assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && out_last |=> in_ready && !out_valid)
    else $error("block not idle after last beat");

endmodule

bind discrete_lyapunov_smith_solver_unit lyap_checker u_lyap_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .in_mode   (in_ch.mode),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_last  (out_ch.last)
);

// ----- test/tb_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the Smith-iteration Lyapunov solver. Matrix
// elements and solve requests go in over the input channel. A built-in
// fixed-point predictor computes every emitted P element, and each output
// beat is checked against the oldest prediction. Phases change the
// configuration over APB and vary source idling and sink stalls.
// ----------------------------------------------------------------------------
module tb_top;
  import lyap_pkg::*;

  localparam logic [1:0] MODE_UNUSED = 2'd3;
  localparam int QUIET_LIMIT = 60000;
  localparam int NUM_PHASES  = 8;
  localparam int PHASE_ITEMS = 38;

  typedef struct {
    logic [2:0]  r;
    logic [2:0]  c;
    logic [31:0] v;
    logic        conv;
    logic [15:0] iters;
    logic        last;
  } p_elem_t;

  // Scoreboard with its own copy of the solver state
  class solution_board;
    logic signed [31:0] a_m[64];
    logic signed [31:0] q_m[64];
    logic signed [31:0] p_m[64];
    logic signed [31:0] pa_m[64];
    logic [3:0]  dim;
    logic [15:0] iter_lim;
    logic [31:0] tol_sq;
    p_elem_t     pending[$];
    int          errors;

    function new();
      dim = 4'd8;
      iter_lim = 16'd5000;
      tol_sq = 32'd1;
      errors = 0;
      foreach (a_m[x]) begin
        a_m[x] = '0; q_m[x] = '0; p_m[x] = '0; pa_m[x] = '0;
      end
    endfunction

    function automatic longint round_q(longint prod);
      return (prod + (64'sd1 <<< 23)) >>> 24;
    endfunction

    function automatic logic signed [31:0] clamp32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
    endfunction

    function void note_input(logic [1:0] md, logic [2:0] r, logic [2:0] c, logic [31:0] v);
      int n;
      int it;
      bit conv;
      bit big;
      longint unsigned diff;
      longint s;
      longint d;
      logic signed [31:0] np;
      logic [15:0] used;
      p_elem_t e;
      if (md == MODE_LOAD_A) a_m[{r, c}] = v;
      else if (md == MODE_LOAD_Q) q_m[{r, c}] = v;
      if (md != MODE_SOLVE) return;
      n = (dim == 0) ? 1 : (dim > 8) ? 8 : dim;
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) p_m[i*8+j] = q_m[i*8+j];
      conv = 0;
      used = '0;
      for (it = 0; it < iter_lim; it++) begin
        diff = 0;
        big = 0;
        // P * A
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) begin
            s = 0;
            for (int k = 0; k < n; k++)
              s += round_q(longint'(p_m[i*8+k]) * longint'(a_m[k*8+j]));
            pa_m[i*8+j] = clamp32(s);
          end
        // Q + A^T * (P * A), with squared change
        for (int i = 0; i < n; i++)
          for (int j = 0; j < n; j++) begin
            s = 0;
            for (int k = 0; k < n; k++)
              s += round_q(longint'(a_m[k*8+i]) * longint'(pa_m[k*8+j]));
            np = clamp32(longint'(q_m[i*8+j]) + longint'(clamp32(s)));
            d = longint'(np) - longint'(p_m[i*8+j]);
            if (d < 0) d = -d;
            if (d >= 65536) big = 1;
            else diff += d * d;
            p_m[i*8+j] = np;
          end
        used = 16'(it + 1);
        if (!big && diff < tol_sq) begin
          conv = 1;
          break;
        end
      end
      for (int i = 0; i < n; i++)
        for (int j = 0; j < n; j++) begin
          e.r = 3'(i); e.c = 3'(j); e.v = p_m[i*8+j];
          e.conv = conv; e.iters = used;
          e.last = (i == n-1 && j == n-1);
          pending.push_back(e);
        end
    endfunction

    function void check_beat(p_elem_t got);
      p_elem_t want;
      if (pending.size() == 0) begin
        $display("%0t: unexpected beat row %0d col %0d value %h", $time, got.r, got.c, got.v);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.r !== want.r || got.c !== want.c || got.v !== want.v ||
          got.conv !== want.conv || got.iters !== want.iters || got.last !== want.last) begin
        $display("%0t: mismatch expected r%0d c%0d p=%h conv=%0b it=%0d last=%0b",
                 $time, want.r, want.c, want.v, want.conv, want.iters, want.last);
        $display("%0t:          actual   r%0d c%0d p=%h conv=%0b it=%0d last=%0b",
                 $time, got.r, got.c, got.v, got.conv, got.iters, got.last);
        errors++;
      end
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  lyap_in_if  in_ch ();
  lyap_out_if out_ch ();

  discrete_lyapunov_smith_solver_unit i_dut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  solution_board board = new();
  int src_idle_pct;
  int snk_stall_pct;
  int quiet_cycles;
  p_elem_t beat;

  always #5 clk = ~clk;

  // Sink: random stalls, check every accepted beat
  always @(posedge clk) begin
    out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
    if (!rst && out_ch.valid && out_ch.ready) begin
      beat.r = out_ch.out_row; beat.c = out_ch.out_col; beat.v = out_ch.p_value;
      beat.conv = out_ch.converged; beat.iters = out_ch.iterations_used;
      beat.last = out_ch.last;
      board.check_beat(beat);
    end
  end

  // Watchdog on cycles with no beat on any channel
  always @(posedge clk) begin
    if (rst || psel || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
      quiet_cycles <= 0;
    else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Simulation FAILED");
      $finish;
    end else
      quiet_cycles <= quiet_cycles + 1;
  end

  task automatic write_reg(logic [1:0] idx, logic [31:0] data);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 2'b00}; pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    @(posedge clk);
  endtask

  // Only called once no result is pending
  task automatic configure(logic [3:0] dim, logic [15:0] lim, logic [31:0] tol);
    repeat (20) @(posedge clk);
    write_reg(REG_DIMENSION, {28'd0, dim});
    write_reg(REG_ITER_LIM, {16'd0, lim});
    write_reg(REG_TOL_SQ, tol);
    board.dim = dim; board.iter_lim = lim; board.tol_sq = tol;
  endtask

  task automatic send_beat(logic [1:0] md, logic [2:0] r, logic [2:0] c, logic [31:0] v);
    while ($urandom_range(99) < src_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(posedge clk);
    end
    in_ch.valid <= 1'b1;
    in_ch.mode <= md; in_ch.row <= r; in_ch.col <= c; in_ch.value <= v;
    do @(posedge clk); while (!in_ch.ready);
    board.note_input(md, r, c, v);
  endtask

  task automatic drain();
    in_ch.valid <= 1'b0;
    while (board.pending.size() != 0) @(posedge clk);
  endtask

  function automatic logic [31:0] small_val();
    return $urandom_range(2097152) - 1048576;
  endfunction

  initial begin
    logic [3:0]  ph_dim[NUM_PHASES]  = '{4'd8, 4'd1, 4'd0, 4'd15, 4'd1, 4'd3, 4'd5, 4'd2};
    logic [15:0] ph_lim[NUM_PHASES]  = '{16'd3, 16'd0, 16'd4, 16'd2, 16'd65535, 16'd12,
                                         16'd6, 16'd9};
    logic [31:0] ph_tol[NUM_PHASES]  = '{32'd1, 32'd1, 32'd0, 32'd0, 32'hffff_ffff, 32'd5000,
                                         32'd100000, 32'd1};
    bit          ph_full[NUM_PHASES] = '{0, 1, 1, 1, 0, 0, 0, 1};
    int          pick;
    logic [1:0]  md;
    logic [31:0] v;

    rst <= 1'b1;
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0; paddr <= '0; pwdata <= '0;
    in_ch.valid <= 1'b0; in_ch.mode <= '0; in_ch.row <= '0; in_ch.col <= '0;
    in_ch.value <= '0;
    src_idle_pct = 0;
    snk_stall_pct = 0;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Fill both stores so no solve reads an unwritten entry
    for (int x = 0; x < 64; x++) begin
      send_beat(MODE_LOAD_A, x[5:3], x[2:0], small_val());
      send_beat(MODE_LOAD_Q, x[5:3], x[2:0], small_val());
    end
    drain();

    // Directed: extreme values, unused mode, full and tiny orders
    configure(4'd8, 16'd2, 32'd0);
    send_beat(MODE_LOAD_A, 3'd7, 3'd7, 32'h8000_0000);
    send_beat(MODE_LOAD_A, 3'd0, 3'd0, 32'h7fff_ffff);
    send_beat(MODE_LOAD_Q, 3'd7, 3'd0, 32'h8000_0000);
    send_beat(MODE_LOAD_Q, 3'd0, 3'd7, 32'h7fff_ffff);
    send_beat(MODE_LOAD_Q, 3'd3, 3'd3, 32'h0000_0000);
    send_beat(MODE_UNUSED, 3'd5, 3'd2, 32'hdead_beef);
    send_beat(MODE_SOLVE, 3'd0, 3'd0, 32'd0);
    send_beat(MODE_LOAD_A, 3'd0, 3'd0, 32'h0040_0000);
    send_beat(MODE_LOAD_Q, 3'd0, 3'd0, 32'h0100_0000);
    drain();
    configure(4'd1, 16'd65535, 32'd1);
    send_beat(MODE_SOLVE, 3'd7, 3'd7, 32'hffff_ffff);
    drain();

    // Random phases over settings and flow-control patterns
    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      configure(ph_dim[ph], ph_lim[ph], ph_tol[ph]);
      case (ph % 4)
        0: begin src_idle_pct = 0;  snk_stall_pct = 0;  end
        1: begin src_idle_pct = 87; snk_stall_pct = 0;  end
        2: begin src_idle_pct = 0;  snk_stall_pct = 87; end
        default: begin src_idle_pct = 26; snk_stall_pct = 26; end
      endcase
      // Order-one long-limit phase needs a contracting top-left element
      if (ph_lim[ph] == 16'hffff) begin
        send_beat(MODE_LOAD_A, 3'd0, 3'd0, small_val());
        send_beat(MODE_LOAD_Q, 3'd0, 3'd0, small_val());
      end
      for (int it = 0; it < PHASE_ITEMS; it++) begin
        if (ph == 5 && it == 20) drain();
        pick = $urandom_range(99);
        md = (pick < 8) ? MODE_SOLVE : (pick < 11) ? MODE_UNUSED :
             (pick < 55) ? MODE_LOAD_A : MODE_LOAD_Q;
        v = ph_full[ph] ? $urandom() : small_val();
        send_beat(md, 3'($urandom_range(7)), 3'($urandom_range(7)), v);
      end
      send_beat(MODE_SOLVE, 3'd0, 3'd0, 32'd0);
      drain();
    end

    src_idle_pct = 0;
    snk_stall_pct = 0;
    repeat (200) @(posedge clk);
    if (board.errors == 0 && board.pending.size() == 0)
      $display("Simulation PASSED");
    else
      $display("Simulation FAILED");
    $finish;
  end

endmodule
